FILE: rtl/core/fblp_pkg.sv
// Shared types and constants for the fixed-block free-list pool.
// No dependencies; used by fblp_ctrl, fblp_dp and the top level.
package fblp_pkg;

    // Default pool depth (entries in the link memory)
    localparam int unsigned MAX_BLOCKS_DEF = 256;

    // Field widths fixed by the stream format
    localparam int unsigned OP_W     = 2;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TDATA_W  = 16;

    // Configuration port
    localparam int unsigned APB_AW          = 3;
    localparam int unsigned APB_DW          = 32;
    localparam int unsigned COUNT_W         = 9;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;
    localparam logic REG_BLOCK_COUNT = 1'b0;   // register select, paddr[2]

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_DESTROY = 2'd3
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_PARAM = 2'd2
    } status_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_POP
    } state_e_t;

    // Datapath -> controller
    typedef struct packed {
        logic  out_free;    // result register empty or draining
        op_e_t opcode;      // opcode of the beat on the input
        logic  alloc_ok;    // pool valid and list not empty
        logic  free_ok;     // index below the effective count
        logic  destroy_ok;  // pool currently valid
        logic  count_zero;  // effective count is zero
        logic  walk_last;   // init walk at its final entry
    } sts_t;

    // Controller -> datapath
    typedef struct packed {
        logic      in_ready;
        logic      push;
        logic      clr_valid;
        logic      walk_start;
        logic      walk_step;
        logic      list_set;
        logic      rd_head;
        logic      pop;
        logic      out_load;
        status_e_t out_status;
    } cmd_t;

endpackage

FILE: rtl/core/fblp_ctrl.sv
// Sequencer for the free-list pool: decodes each beat and steps the datapath.
// Depends on fblp_pkg.
module fblp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  fblp_pkg::sts_t  sts,
    output fblp_pkg::cmd_t  cmd
);

    fblp_pkg::state_e_t state_reg, state_next;
    logic fire;

    // no beat is taken while reset is held
    assign fire = in_valid && sts.out_free && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fblp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fblp_pkg::S_IDLE: begin
                if (fire) begin
                    if (sts.opcode == fblp_pkg::OP_INIT && !sts.count_zero) begin
                        state_next = fblp_pkg::S_WALK;
                    end else if (sts.opcode == fblp_pkg::OP_ALLOC && sts.alloc_ok) begin
                        state_next = fblp_pkg::S_POP;
                    end
                end
            end
            fblp_pkg::S_WALK: begin
                if (sts.walk_last) begin
                    state_next = fblp_pkg::S_IDLE;
                end
            end
            fblp_pkg::S_POP: begin
                state_next = fblp_pkg::S_IDLE;
            end
            default: begin
                state_next = fblp_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        cmd.out_status = fblp_pkg::ST_OK;
        unique case (state_reg)
            fblp_pkg::S_IDLE: begin
                cmd.in_ready = sts.out_free && aresetn;
                if (fire) begin
                    unique case (sts.opcode)
                        fblp_pkg::OP_INIT: begin
                            if (sts.count_zero) begin
                                cmd.list_set = 1'b1;
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.walk_start = 1'b1;
                            end
                        end
                        fblp_pkg::OP_ALLOC: begin
                            if (sts.alloc_ok) begin
                                cmd.rd_head = 1'b1;
                            end else begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = fblp_pkg::ST_EMPTY;
                            end
                        end
                        fblp_pkg::OP_FREE: begin
                            cmd.out_load = 1'b1;
                            if (sts.free_ok) begin
                                cmd.push = 1'b1;
                            end else begin
                                cmd.out_status = fblp_pkg::ST_PARAM;
                            end
                        end
                        fblp_pkg::OP_DESTROY: begin
                            cmd.out_load = 1'b1;
                            if (sts.destroy_ok) begin
                                cmd.clr_valid = 1'b1;
                            end else begin
                                cmd.out_status = fblp_pkg::ST_PARAM;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b0;
                        end
                    endcase
                end
            end
            fblp_pkg::S_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    cmd.list_set = 1'b1;
                    cmd.out_load = 1'b1;
                end
            end
            fblp_pkg::S_POP: begin
                cmd.pop      = 1'b1;
                cmd.out_load = 1'b1;
            end
            default: begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/fblp_dp.sv
// Datapath of the free-list pool: link memory, list head, init walk counter
// and the result register. Depends on fblp_pkg; driven by fblp_ctrl.
module fblp_dp #(
    parameter int unsigned MAX_BLOCKS = fblp_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [fblp_pkg::OP_W-1:0]        in_opcode,
    input  logic [fblp_pkg::IDX_W-1:0]       in_block_index,
    input  logic [fblp_pkg::COUNT_W-1:0]     block_count,
    input  fblp_pkg::cmd_t                   cmd,
    output fblp_pkg::sts_t                   sts,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [fblp_pkg::IDX_W-1:0]       out_granted_index,
    output logic [fblp_pkg::STATUS_W-1:0]    out_status
);

    localparam int unsigned AW   = $clog2(MAX_BLOCKS);       // memory address
    localparam int unsigned LW   = $clog2(MAX_BLOCKS + 1);   // link incl. end mark
    localparam int unsigned CMPW = (LW > fblp_pkg::COUNT_W) ? LW : fblp_pkg::COUNT_W;
    localparam logic [LW-1:0]   END_MARK = LW'(MAX_BLOCKS);
    localparam logic [CMPW-1:0] MAX_CMP  = CMPW'(MAX_BLOCKS);

    logic [LW-1:0] link_mem [MAX_BLOCKS];

    logic [LW-1:0]  head_reg, head_next;
    logic           valid_reg, valid_next;
    logic [AW-1:0]  walk_reg;
    logic [LW-1:0]  rd_data_reg;
    logic           m_valid_reg;
    logic [fblp_pkg::IDX_W-1:0]    granted_reg;
    logic [fblp_pkg::STATUS_W-1:0] status_reg;

    logic [LW-1:0]  eff_count;
    logic [CMPW-1:0] count_ext;
    logic [LW-1:0]  walk_inc;
    logic           walk_last;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [LW-1:0]  mem_wdata;

    // Effective count: block_count clamped to the pool depth
    assign count_ext = CMPW'(block_count);
    assign eff_count = (count_ext > MAX_CMP) ? END_MARK : LW'(count_ext);

    assign walk_inc  = LW'(walk_reg) + LW'(1);
    assign walk_last = (walk_inc == eff_count);

    assign sts.out_free   = !m_valid_reg || out_ready;
    assign sts.opcode     = fblp_pkg::op_e_t'(in_opcode);
    assign sts.alloc_ok   = valid_reg && (head_reg < END_MARK);
    assign sts.free_ok    = CMPW'(in_block_index) < CMPW'(eff_count);
    assign sts.destroy_ok = valid_reg;
    assign sts.count_zero = (eff_count == '0);
    assign sts.walk_last  = walk_last;

    // Single write port: init walk or push
    always_comb begin
        mem_we    = cmd.walk_step || cmd.push;
        mem_waddr = walk_reg;
        mem_wdata = walk_last ? END_MARK : walk_inc;
        if (cmd.push) begin
            mem_waddr = AW'(in_block_index);
            mem_wdata = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_head) begin
            rd_data_reg <= link_mem[head_reg[AW-1:0]];
        end
    end

    always_comb begin
        head_next  = head_reg;
        valid_next = valid_reg;
        if (cmd.list_set) begin
            head_next  = sts.count_zero ? END_MARK : '0;
            valid_next = 1'b1;
        end else if (cmd.push) begin
            head_next = LW'(in_block_index);
        end else if (cmd.pop) begin
            head_next = rd_data_reg;
        end
        if (cmd.clr_valid) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= END_MARK;
            valid_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            valid_reg <= valid_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            walk_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_reg <= AW'(walk_inc);
        end
        if (cmd.out_load) begin
            granted_reg <= cmd.pop ? fblp_pkg::IDX_W'(head_reg) : '0;
            status_reg  <= cmd.out_status;
        end
    end

    assign out_valid         = m_valid_reg;
    assign out_granted_index = granted_reg;
    assign out_status        = status_reg;

endmodule

FILE: rtl/core/fixed_block_free_list_pool_top.sv
// Fixed-size block pool kept as a LIFO free list of block indices. Each
// input beat carries one operation (init, alloc, free, destroy) and yields
// exactly one result beat. Free, destroy, a failed alloc and an init with a
// zero count load the result as the beat is taken; a successful alloc
// first reads the head's link, then loads the result; init steps the walk
// state, writing one link per cycle through the single write port, and
// loads the result at its final entry. A new beat is taken whenever the
// sequencer is idle and the result register is empty or being drained.
// The link memory needs no clearing pass after reset: only init and free
// write it, and alloc reads only entries named by the head. block_count is
// written over APB at byte address 0 and is read by init and by the free
// range check. Instantiates fblp_ctrl and fblp_dp; depends on fblp_pkg.
module fixed_block_free_list_pool_top #(
    parameter int unsigned MAX_BLOCKS = fblp_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fblp_pkg::TDATA_W-1:0]  s_tdata,   // [1:0] opcode, [9:2] block_index
    // Result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fblp_pkg::TDATA_W-1:0]  m_tdata,   // [7:0] granted_index, [9:8] status
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fblp_pkg::APB_AW-1:0]   paddr,
    input  logic [fblp_pkg::APB_DW-1:0]   pwdata,
    output logic [fblp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    fblp_pkg::cmd_t cmd;
    fblp_pkg::sts_t sts;

    logic [fblp_pkg::COUNT_W-1:0]  block_count_reg;
    logic [fblp_pkg::IDX_W-1:0]    granted_index;
    logic [fblp_pkg::STATUS_W-1:0] status;
    logic                          cfg_wr;

    // APB: zero wait states, single register at byte 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fblp_pkg::REG_BLOCK_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= fblp_pkg::BLOCK_COUNT_RST;
        end else if (cfg_wr) begin
            block_count_reg <= pwdata[fblp_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == fblp_pkg::REG_BLOCK_COUNT)
                    ? fblp_pkg::APB_DW'(block_count_reg) : '0;

    fblp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    fblp_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_opcode         (s_tdata[1:0]),
        .in_block_index    (s_tdata[9:2]),
        .block_count       (block_count_reg),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_granted_index (granted_index),
        .out_status        (status)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = {6'b0, status, granted_index};

endmodule
